FILE: hw/rtl/wpsm_pkg.sv
// Shared types and constants for the wheel pulse speed meter.
// No dependencies; used by every module of the block but wpsm_cell.
`default_nettype none

package wpsm_pkg;

	localparam int WINDOW_LOG2_DEF = 5;
	localparam int TICK_MS_DEF     = 50;
	localparam int MAX_PULSES_DEF  = 50;

	localparam int CNT_W      = 16;
	localparam int DIST_W     = 20;
	localparam int DIFF_OUT_W = 6;
	localparam int SPEED_W    = 16;
	localparam int TOTAL_W    = 32;

	localparam logic [DIST_W-1:0]  DIST_RESET = 20'd165769;
	localparam logic [SPEED_W-1:0] SPEED_MAX  = 16'hFFFF;

	// Speed divisor is TICK_MS * window length * RECIP_NUM / RECIP_DEN.
	localparam longint unsigned RECIP_NUM = 277778;
	localparam longint unsigned RECIP_DEN = 10000;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_READ  = 2'd2
	} err_t;

	// Fields that ride along with a word down the speed pipeline.
	typedef struct packed {
		logic [DIFF_OUT_W-1:0] diff;
		logic [TOTAL_W-1:0]    total;
		err_t                  err;
	} side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wpsm_cell.sv
// One cell of the moving-window shift chain: holds one pulse count.
// No dependencies.
`default_nettype none

module wpsm_cell #(
	parameter int W = 6
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         shift,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wpsm_speed.sv
// Speed pipeline: window sum times distance, rounded division by a constant
// through a reciprocal multiply, saturation and the held speed. Uses wpsm_pkg.
`default_nettype none

module wpsm_speed #(
	parameter int WINDOW_LOG2 = wpsm_pkg::WINDOW_LOG2_DEF,
	parameter int TICK_MS     = wpsm_pkg::TICK_MS_DEF,
	parameter int SUM_W       = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [wpsm_pkg::DIST_W-1:0]   dist_um,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [SUM_W-1:0]              sum,
	input  wire wpsm_pkg::side_t               side_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [wpsm_pkg::SPEED_W-1:0]  speed,
	output wpsm_pkg::side_t                    side_out
);

	localparam logic [63:0] K = 64'(TICK_MS) * (64'd1 << WINDOW_LOG2)
		* 64'(wpsm_pkg::RECIP_NUM) / 64'(wpsm_pkg::RECIP_DEN);
	localparam logic [63:0] HALF = K / 64'd2;
	localparam int NW = SUM_W + wpsm_pkg::DIST_W + 1;
	localparam int KW = $clog2(K);
	localparam int MW = NW + 1;
	localparam int S  = NW + KW;
	localparam logic [63:0] M64 = ((64'd1 << S) + K - 64'd1) / K;
	localparam logic [MW-1:0] M = MW'(M64);
	localparam int H  = NW / 2;
	localparam int HW = NW - H;
	localparam int FW = NW + MW;
	localparam int QW = FW - S;
	localparam int QX = (QW > wpsm_pkg::SPEED_W) ? QW : wpsm_pkg::SPEED_W;

	logic                          valid_s2, valid_s3, valid_s4;
	logic                          ready_s3, ready_s4;
	logic [NW-1:0]                 num_s2;
	logic [H+MW-1:0]               lo_s3;
	logic [HW+MW-1:0]              hi_s3;
	wpsm_pkg::side_t               side_s2, side_s3, side_s4;
	logic [wpsm_pkg::SPEED_W-1:0]  speed_s4;
	logic [wpsm_pkg::SPEED_W-1:0]  hold_q;
	logic [NW-1:0]                 num_c;
	logic [FW-1:0]                 full_c;
	logic [QX-1:0]                 quot_c;
	logic [wpsm_pkg::SPEED_W-1:0]  sat_c;

	assign ready_s4 = !valid_s4 || !out_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = !valid_s2 || ready_s3;

	assign num_c  = NW'(sum) * NW'(dist_um) + NW'(HALF);
	assign full_c = {hi_s3, {H{1'b0}}} + FW'(lo_s3);
	assign quot_c = QX'(full_c[FW-1:S]);
	assign sat_c  = (quot_c > QX'(wpsm_pkg::SPEED_MAX)) ? wpsm_pkg::SPEED_MAX
		: quot_c[wpsm_pkg::SPEED_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			hold_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
				// A word with an error shows the speed of the last good word.
				if (valid_s3 && side_s3.err == wpsm_pkg::ERR_OK) begin
					hold_q <= sat_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			num_s2  <= num_c;
			side_s2 <= side_in;
		end
		if (ready_s3 && valid_s2) begin
			lo_s3   <= (H+MW)'(num_s2[H-1:0]) * (H+MW)'(M);
			hi_s3   <= (HW+MW)'(num_s2[NW-1:H]) * (HW+MW)'(M);
			side_s3 <= side_s2;
		end
		if (ready_s4 && valid_s3) begin
			speed_s4 <= (side_s3.err == wpsm_pkg::ERR_OK) ? sat_c : hold_q;
			side_s4  <= side_s3;
		end
	end

	assign out_valid = valid_s4;
	assign speed     = speed_s4;
	assign side_out  = side_s4;

endmodule

`default_nettype wire

FILE: hw/rtl/wheel_pulse_speed_meter.sv
// Wheel pulse speed meter top level: front stage, moving-window cell chain
// and speed pipeline. Uses wpsm_pkg, wpsm_cell and wpsm_speed.
//
// Usage: once per sampling tick, present a raw pulse counter reading on
// counter_value with read_ok and raise in_valid; the word is taken at an
// edge where in_stall is low. Each input word gives exactly one result word
// on the output channel (pulse_diff, speed_tenth_kmh, wheel_total, error),
// taken at an edge where out_valid is high and out_stall is low.
// A new word is taken every cycle while in_stall is low; the four pipeline
// registers each take a word as soon as the one ahead moves, so while the
// receiver stalls the block keeps taking input until all four stages hold
// a word, and then raises in_stall. The window of the last 2^WINDOW_LOG2
// good counts lives in a chain of cells that shifts by one on every good
// word. Reset clears the previous reading, the window, the totals and the
// held speed, and sets the distance register to its default. The distance
// register is written through cfg_we and cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
`default_nettype none

module wheel_pulse_speed_meter #(
	parameter int WINDOW_LOG2         = wpsm_pkg::WINDOW_LOG2_DEF,
	parameter int TICK_MS             = wpsm_pkg::TICK_MS_DEF,
	parameter int MAX_PULSES_PER_TICK = wpsm_pkg::MAX_PULSES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [wpsm_pkg::DIST_W-1:0]      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic signed [wpsm_pkg::CNT_W-1:0] counter_value,
	input  wire logic                             read_ok,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [wpsm_pkg::DIFF_OUT_W-1:0]  pulse_diff,
	output logic      [wpsm_pkg::SPEED_W-1:0]     speed_tenth_kmh,
	output logic      [wpsm_pkg::TOTAL_W-1:0]     wheel_total,
	output logic      [1:0]                       error
);

	localparam int WIN_LEN = 1 << WINDOW_LOG2;
	localparam int DIFF_W  = $clog2(MAX_PULSES_PER_TICK + 1);
	localparam int SUM_W   = $clog2(MAX_PULSES_PER_TICK * WIN_LEN + 1);
	localparam int DX      = (DIFF_W > wpsm_pkg::DIFF_OUT_W) ? DIFF_W
		: wpsm_pkg::DIFF_OUT_W;
	localparam int CW      = wpsm_pkg::CNT_W;

	logic [wpsm_pkg::DIST_W-1:0]  dist_q;
	logic [CW-1:0]                prev_count_q;
	logic [SUM_W-1:0]             sum_q;
	logic [wpsm_pkg::TOTAL_W-1:0] total_q;

	logic                         valid_s1;
	logic [SUM_W-1:0]             sum_s1;
	wpsm_pkg::side_t              side_s1;

	logic                         ready_s1, speed_ready, accept, good;
	logic signed [CW:0]           diff_c;
	logic                         in_range;
	logic [DIFF_W-1:0]            d_c;
	logic [DX-1:0]                d_ext;
	logic [SUM_W-1:0]             sum_next;
	logic [wpsm_pkg::TOTAL_W-1:0] total_next;
	wpsm_pkg::side_t              side_c;
	wpsm_pkg::side_t              side_out;
	logic [DIFF_W-1:0]            tap [WIN_LEN];

	assign diff_c   = {counter_value[CW-1], counter_value}
		- {prev_count_q[CW-1], prev_count_q};
	assign in_range = !diff_c[CW] && (diff_c[CW-1:0] <= CW'(MAX_PULSES_PER_TICK));
	assign d_c      = diff_c[DIFF_W-1:0];
	assign d_ext    = DX'(d_c);

	assign ready_s1 = !valid_s1 || speed_ready;
	assign in_stall = !ready_s1;
	assign accept   = in_valid && ready_s1;
	assign good     = accept && read_ok && in_range;

	// The last cell holds the count that leaves the window on this shift.
	assign sum_next   = sum_q - SUM_W'(tap[WIN_LEN-1]) + SUM_W'(d_c);
	assign total_next = total_q + wpsm_pkg::TOTAL_W'(d_c);

	always_comb begin
		side_c.diff  = '0;
		side_c.total = total_q;
		if (!read_ok) begin
			side_c.err = wpsm_pkg::ERR_READ;
		end else if (!in_range) begin
			side_c.err = wpsm_pkg::ERR_RANGE;
		end else begin
			side_c.err   = wpsm_pkg::ERR_OK;
			side_c.diff  = d_ext[wpsm_pkg::DIFF_OUT_W-1:0];
			side_c.total = total_next;
		end
	end

	genvar i;
	generate
		for (i = 0; i < WIN_LEN; i++) begin : g_cell
			if (i == 0) begin : g_head
				wpsm_cell #(.W(DIFF_W)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (good),
					.d      (d_c),
					.q      (tap[i])
				);
			end else begin : g_body
				wpsm_cell #(.W(DIFF_W)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (good),
					.d      (tap[i-1]),
					.q      (tap[i])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q       <= wpsm_pkg::DIST_RESET;
			prev_count_q <= '0;
			sum_q        <= '0;
			total_q      <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				dist_q <= cfg_data;
			end
			if (accept && read_ok) begin
				prev_count_q <= counter_value;
			end
			if (good) begin
				sum_q   <= sum_next;
				total_q <= total_next;
			end
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1  <= sum_next;
			side_s1 <= side_c;
		end
	end

	wpsm_speed #(
		.WINDOW_LOG2 (WINDOW_LOG2),
		.TICK_MS     (TICK_MS),
		.SUM_W       (SUM_W)
	) u_speed (
		.clk       (clk),
		.arst_n    (arst_n),
		.dist_um   (dist_q),
		.in_valid  (valid_s1),
		.in_ready  (speed_ready),
		.sum       (sum_s1),
		.side_in   (side_s1),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.speed     (speed_tenth_kmh),
		.side_out  (side_out)
	);

	assign pulse_diff  = side_out.diff;
	assign wheel_total = side_out.total;
	assign error       = side_out.err;

endmodule

`default_nettype wire

FILE: hw/rtl/wpsm_checker.sv
// Port-level checker for the wheel pulse speed meter, bound to the top level.
// Uses wpsm_pkg.
`default_nettype none

module wpsm_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic [wpsm_pkg::DIFF_OUT_W-1:0]     pulse_diff,
	input wire logic [wpsm_pkg::SPEED_W-1:0]        speed_tenth_kmh,
	input wire logic [wpsm_pkg::TOTAL_W-1:0]        wheel_total,
	input wire logic [1:0]                          error
);

	logic [wpsm_pkg::SPEED_W-1:0] last_speed_q;
	logic [wpsm_pkg::TOTAL_W-1:0] last_total_q;
	logic                         out_take;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_speed_q <= '0;
			last_total_q <= '0;
		end else if (out_take) begin
			last_speed_q <= speed_tenth_kmh;
			last_total_q <= wheel_total;
		end
	end

	// A rejected or failed word counts no pulses.
	a_err_no_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != wpsm_pkg::ERR_OK |-> pulse_diff == '0)
		else $error("pulse count on an error word");

	// A word with an error repeats the speed of the word before it.
	a_err_holds_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != wpsm_pkg::ERR_OK |-> speed_tenth_kmh == last_speed_q)
		else $error("speed not held on an error word");

	// The total advances by exactly this word's count.
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> wheel_total
			== last_total_q + wpsm_pkg::TOTAL_W'(pulse_diff))
		else $error("wheel total does not follow the counts");

	// A stalled result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(speed_tenth_kmh)
			&& $stable(wheel_total) && $stable(error))
		else $error("stalled output word changed");

endmodule

bind wheel_pulse_speed_meter wpsm_checker u_wpsm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.pulse_diff      (pulse_diff),
	.speed_tenth_kmh (speed_tenth_kmh),
	.wheel_total     (wheel_total),
	.error           (error)
);

`default_nettype wire

FILE: test/wheel_pulse_speed_meter_test.sv
// Self-checking testbench for the wheel pulse speed meter.
// Needs wpsm_pkg and the wheel_pulse_speed_meter RTL. It predicts every result word
// in SystemVerilog and drives both channels with random idle and stall.
`default_nettype none

module wheel_pulse_speed_meter_test;
	import wpsm_pkg::*;

	localparam int WINDOW_LEN = 1 << WINDOW_LOG2_DEF;
	localparam longint unsigned SPEED_DIV =
		longint'(TICK_MS_DEF) * WINDOW_LEN * RECIP_NUM / RECIP_DEN;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [DIFF_OUT_W-1:0] diff;
		logic [SPEED_W-1:0]    speed;
		logic [TOTAL_W-1:0]    total;
		err_t                  err;
	} meter_reading_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [DIST_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [CNT_W-1:0]  counter_value = '0;
	logic                     read_ok = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [DIFF_OUT_W-1:0]    pulse_diff;
	logic [SPEED_W-1:0]       speed_tenth_kmh;
	logic [TOTAL_W-1:0]       wheel_total;
	logic [1:0]               error_code;

	wheel_pulse_speed_meter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.counter_value(counter_value),
		.read_ok(read_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_diff(pulse_diff),
		.speed_tenth_kmh(speed_tenth_kmh),
		.wheel_total(wheel_total),
		.error(error_code)
	);

	// Predictor state of the meter.
	logic [DIST_W-1:0]           distance_um = DIST_RESET;
	logic signed [CNT_W-1:0]     last_count = '0;
	logic [DIFF_OUT_W-1:0]       window_ring [WINDOW_LEN];
	logic [WINDOW_LOG2_DEF-1:0]  ring_ptr = '0;
	int unsigned                 window_total = 0;
	logic [TOTAL_W-1:0]          good_pulses = '0;
	logic [SPEED_W-1:0]          held_speed = '0;

	meter_reading_t expected_readings[$];

	int in_gap_max = 14;
	int out_stall_max = 14;
	int stall_left = 0;
	int mismatches = 0;
	int readings_ok = 0;
	int readings_range = 0;
	int readings_failed = 0;
	int distance_writes = 0;
	int cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		foreach (window_ring[i])
			window_ring[i] = '0;
	end

	function automatic meter_reading_t predict_reading(logic signed [CNT_W-1:0] reading,
			logic ok);
		meter_reading_t r;
		int delta;
		longint unsigned scaled;
		r.diff = '0;
		r.err = ERR_OK;
		if (!ok) begin
			r.err = ERR_READ;
		end else begin
			delta = int'(reading) - int'(last_count);
			last_count = reading;
			if (delta < 0 || delta > MAX_PULSES_DEF) begin
				r.err = ERR_RANGE;
			end else begin
				good_pulses = good_pulses + TOTAL_W'(delta);
				window_total = window_total - window_ring[ring_ptr] + delta;
				window_ring[ring_ptr] = DIFF_OUT_W'(delta);
				ring_ptr = ring_ptr + 1'b1;
				scaled = (64'(window_total) * 64'(distance_um) + SPEED_DIV / 2) / SPEED_DIV;
				held_speed = (scaled > 64'(SPEED_MAX)) ? SPEED_MAX : scaled[SPEED_W-1:0];
				r.diff = DIFF_OUT_W'(delta);
			end
		end
		r.speed = held_speed;
		r.total = good_pulses;
		return r;
	endfunction

	// Presents one counter word and waits until the block takes it. Valid stays
	// high after acceptance so that a zero gap keeps the channel busy.
	task automatic send_word(logic signed [CNT_W-1:0] reading, logic ok);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		counter_value = reading;
		read_ok = ok;
		do @(posedge clk); while (in_stall);
		expected_readings.push_back(predict_reading(reading, ok));
	endtask

	// Lowers valid and waits for every outstanding result and the pipeline tail.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_distance(logic [DIST_W-1:0] value);
		wait_idle();
		cfg_we = 1'b1;
		cfg_data = value;
		distance_um = value;
		distance_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly plausible ticks that follow the previous reading, with some jumps,
	// failed reads and arbitrary readings mixed in.
	task automatic send_random_tick(bit fast);
		int pick;
		logic signed [CNT_W-1:0] reading;
		logic ok;
		pick = $urandom_range(0, 99);
		ok = 1'b1;
		if (pick < 76)
			reading = last_count + CNT_W'(fast ? $urandom_range(40, 50) : $urandom_range(0, 50));
		else if (pick < 80)
			reading = last_count + CNT_W'($urandom_range(51, 30000));
		else if (pick < 84)
			reading = last_count - CNT_W'($urandom_range(1, 200));
		else if (pick < 92) begin
			reading = CNT_W'($urandom);
			ok = 1'b0;
		end else
			reading = CNT_W'($urandom);
		send_word(reading, ok);
	endtask

	task automatic run_random(int count, bit fast);
		repeat (count) send_random_tick(fast);
	endtask

	task automatic test_edge_readings();
		in_gap_max = 14;
		out_stall_max = 14;
		send_word(16'sh1234, 1'b0);      // failed read straight after reset
		send_word(16'sh0000, 1'b1);
		send_word(16'sd50, 1'b1);        // largest good difference
		send_word(16'sd101, 1'b1);       // one above the limit
		send_word(16'sd101, 1'b1);
		send_word(16'sd100, 1'b1);       // counter went backward
		send_word(16'sh7000, 1'b0);      // failed read must not move the previous value
		send_word(16'sd120, 1'b1);
		send_word(16'sh7FFF, 1'b1);
		send_word(16'sh8000, 1'b1);      // counter wrap gives a negative difference
		send_word(16'sh8032, 1'b1);
		send_word(16'shFFFF, 1'b1);
		send_word(16'shFFFF, 1'b1);
		send_word(16'sh0000, 1'b1);
		send_word(16'sh5555, 1'b1);
		send_word(16'sh556E, 1'b1);
		send_word(16'sh2AAA, 1'b1);
		send_word(16'sh2ADC, 1'b1);
		send_word(16'shFFFF, 1'b0);
		send_word(16'sh2ADC, 1'b1);
	endtask

	task automatic test_default_distance();
		in_gap_max = 14;
		out_stall_max = 14;
		run_random(450, 1'b0);
	endtask

	task automatic test_back_to_back();
		in_gap_max = 0;
		out_stall_max = 0;
		run_random(250, 1'b0);
	endtask

	task automatic test_top_speed();
		write_distance({DIST_W{1'b1}});
		in_gap_max = 14;
		out_stall_max = 14;
		run_random(300, 1'b1);
	endtask

	task automatic test_zero_distance();
		write_distance('0);
		in_gap_max = 6;
		out_stall_max = 14;
		run_random(180, 1'b1);
	endtask

	task automatic test_unit_distance();
		write_distance(DIST_W'(1));
		in_gap_max = 14;
		out_stall_max = 3;
		run_random(180, 1'b0);
	endtask

	task automatic test_random_distances();
		repeat (3) begin
			write_distance(DIST_W'($urandom));
			in_gap_max = 14;
			out_stall_max = 14;
			run_random(140, 1'($urandom_range(0, 1)));
		end
		write_distance(DIST_RESET);
		run_random(120, 1'b0);
	endtask

	// Receiver holds back while the sender never idles, so the pipeline fills
	// and input stall gets exercised.
	task automatic test_full_pipeline();
		in_gap_max = 0;
		out_stall_max = 14;
		run_random(220, 1'b1);
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		meter_reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result word: diff %0d speed %0d total %0d err %0d",
						pulse_diff, speed_tenth_kmh, wheel_total, error_code);
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				if (pulse_diff !== want.diff || speed_tenth_kmh !== want.speed ||
						wheel_total !== want.total || error_code !== want.err) begin
					if (mismatches < 10)
						$display({"mismatch: expected diff %0d speed %0d total %0d err %0d,",
							" got diff %0d speed %0d total %0d err %0d"},
							want.diff, want.speed, want.total, want.err,
							pulse_diff, speed_tenth_kmh, wheel_total, error_code);
					mismatches++;
				end
				case (want.err)
					ERR_OK:    readings_ok++;
					ERR_RANGE: readings_range++;
					default:   readings_failed++;
				endcase
			end
			stall_left = $urandom_range(0, out_stall_max);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycles, expected_readings.size());
			$display("wheel_pulse_speed_meter_test NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_edge_readings();
		test_default_distance();
		test_back_to_back();
		test_top_speed();
		test_zero_distance();
		test_unit_distance();
		test_random_distances();
		test_full_pipeline();
		wait_idle();
		$display("checked %0d good, %0d out-of-range and %0d failed-read results",
			readings_ok, readings_range, readings_failed);
		$display("distance register rewritten %0d times; %0d mismatches",
			distance_writes, mismatches);
		if (mismatches == 0)
			$display("wheel_pulse_speed_meter_test OK");
		else
			$display("wheel_pulse_speed_meter_test NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

FILE: wheel_pulse_speed_meter.f
hw/rtl/wpsm_pkg.sv
hw/rtl/wpsm_cell.sv
hw/rtl/wpsm_speed.sv
hw/rtl/wheel_pulse_speed_meter.sv
hw/rtl/wpsm_checker.sv
test/wheel_pulse_speed_meter_test.sv
